/* sv/rsbp_pkg.sv */
package rsbp_pkg;

  localparam int PRICE_W = 31;
  localparam int TAG_W   = 16;
  // widest memory address over the supported capacity range (up to 1024 records)
  localparam int ADDR_W  = 10;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic               final_item;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] sorted_price;
    logic [TAG_W-1:0]   sorted_tag;
    logic               end_of_run;
    logic               overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    WS_IN,
    WS_MIN,
    WS_CARRY
  } wsrc_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    wsrc_e             wsrc;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              carry_ld;
    logic              carry_max;
    logic              out_ld;
    logic              out_last;
    logic              out_ovf;
  } cmd_t;

endpackage

/* sv/rsbp_dp.sv */
module rsbp_dp #(
  parameter int MAX_ITEMS = 64,
  parameter int TAG_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsbp_pkg::in_item_t  in_data_i,
  input  rsbp_pkg::cmd_t      cmd_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rsbp_pkg::out_item_t out_data_o,
  output logic                out_free_o
);

  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int TagW  = (TAG_BITS < rsbp_pkg::TAG_W) ? TAG_BITS : rsbp_pkg::TAG_W;
  localparam int PW    = rsbp_pkg::PRICE_W;
  localparam int EW    = PW + TagW;
  localparam int OutTW = rsbp_pkg::TAG_W;

  logic [EW-1:0] mem [MAX_ITEMS];
  logic [EW-1:0] rd_q;
  logic [EW-1:0] carry_q;
  logic [EW-1:0] entry_w;
  logic [EW-1:0] min_w;
  logic [EW-1:0] max_w;
  logic [EW-1:0] wdata;
  logic          gt;

  logic                out_valid_q;
  rsbp_pkg::out_item_t out_data_q;

  assign entry_w = {in_data_i.price, in_data_i.tag[TagW-1:0]};

  // swap only on strictly greater key, which keeps equal prices in load order
  assign gt    = carry_q[EW-1:TagW] > rd_q[EW-1:TagW];
  assign min_w = gt ? rd_q : carry_q;
  assign max_w = gt ? carry_q : rd_q;

  always_comb begin
    case (cmd_i.wsrc)
      rsbp_pkg::WS_IN:    wdata = entry_w;
      rsbp_pkg::WS_MIN:   wdata = min_w;
      rsbp_pkg::WS_CARRY: wdata = carry_q;
      default:            wdata = entry_w;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr[AW-1:0]] <= wdata;
    end
    if (cmd_i.re) begin
      rd_q <= mem[cmd_i.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.carry_ld) begin
      carry_q <= rd_q;
    end else if (cmd_i.carry_max) begin
      carry_q <= max_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_data_q.sorted_price <= rd_q[EW-1:TagW];
      out_data_q.sorted_tag   <= OutTW'(rd_q[TagW-1:0]);
      out_data_q.end_of_run   <= cmd_i.out_last;
      out_data_q.overflow     <= cmd_i.out_ovf;
    end
  end

  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/rsbp_ctrl.sv */
module rsbp_ctrl #(
  parameter int MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_final_i,
  output logic           in_stall_o,
  input  logic           out_free_i,
  output rsbp_pkg::cmd_t cmd_o
);

  localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int AddrW = rsbp_pkg::ADDR_W;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos2_w;
  logic [CW-1:0] idx1_w;
  logic          has_room;

  assign pos2_w   = CW'(pos_q) + CW'(2);
  assign idx1_w   = CW'(idx_q) + CW'(1);
  assign has_room = fill_q < CW'(MAX_ITEMS);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    len_d   = len_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.wsrc = rsbp_pkg::WS_IN;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (has_room) begin
            cmd_o.we    = 1'b1;
            cmd_o.waddr = AddrW'(fill_q[AW-1:0]);
            fill_d      = fill_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_final_i) begin
            len_d   = has_room ? fill_q + CW'(1) : fill_q;
            state_d = S_START;
          end
        end
      end
      S_START: begin
        // fetch entry 0 for the next pass or for the first result
        cmd_o.re    = 1'b1;
        cmd_o.raddr = '0;
        idx_d       = '0;
        state_d     = (len_q <= CW'(1)) ? S_EMIT : S_FIRST;
      end
      S_FIRST: begin
        cmd_o.carry_ld = 1'b1;
        cmd_o.re       = 1'b1;
        cmd_o.raddr    = AddrW'(1);
        pos_d          = '0;
        state_d        = S_CMP;
      end
      S_CMP: begin
        // write the smaller record back, carry the larger one forward
        cmd_o.we        = 1'b1;
        cmd_o.waddr     = AddrW'(pos_q);
        cmd_o.wsrc      = rsbp_pkg::WS_MIN;
        cmd_o.carry_max = 1'b1;
        if (pos2_w < len_q) begin
          cmd_o.re    = 1'b1;
          cmd_o.raddr = AddrW'(pos2_w);
          pos_d       = pos_q + AW'(1);
        end else begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.we    = 1'b1;
        cmd_o.waddr = AddrW'(CW'(pos_q) + CW'(1));
        cmd_o.wsrc  = rsbp_pkg::WS_CARRY;
        len_d       = len_q - CW'(1);
        state_d     = S_START;
      end
      S_EMIT: begin
        if (out_free_i) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = (idx1_w == fill_q);
          cmd_o.out_ovf  = drop_q;
          if (idx1_w == fill_q) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            cmd_o.re    = 1'b1;
            cmd_o.raddr = AddrW'(idx1_w);
            idx_d       = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      len_q   <= '0;
      pos_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o = (state_q != S_LOAD);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_ITEMS))
    else $error("fill count above capacity");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_START || state_q == S_FIRST || state_q == S_CMP || state_q == S_TAIL)
      |-> (len_q <= fill_q && len_q != '0))
    else $error("pass length outside stored set");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.we && cmd_o.re) |-> (cmd_o.waddr != cmd_o.raddr))
    else $error("read and write at the same address");

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> out_free_i)
    else $error("result loaded while output register is held");

  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_ld && cmd_o.out_last) |=> (fill_q == '0 && !drop_q && state_q == S_LOAD))
    else $error("store not emptied after last result");

endmodule

/* sv/record_sort_by_price_top.sv */
// Channel   Direction  Payload                  Handshake
// in        input      rsbp_pkg::in_item_t      in_valid_i / in_stall_o
// out       output     rsbp_pkg::out_item_t     out_valid_o / out_stall_i
//
// Loading takes one cycle per record; records past MAX_ITEMS are dropped.
// A set of n records is sorted by repeated bubble passes, each one record shorter than the last,
// paced by the single-port read and single write of the record memory.
// Results then stream at one per cycle while out_stall_i stays low.
// in_stall_o is high from the final record until the last result is loaded.
// Reset clears control state only; the record memory needs no clearing.
module record_sort_by_price_top #(
  parameter int MAX_ITEMS = 64,
  parameter int TAG_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsbp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsbp_pkg::out_item_t out_data_o
);

  rsbp_pkg::cmd_t cmd;
  logic           out_free;

  rsbp_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.final_item),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  rsbp_dp #(
    .MAX_ITEMS (MAX_ITEMS),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_free_o  (out_free)
  );

endmodule

/* test/record_sort_by_price_top_test.sv */
`timescale 1ns / 100ps

module record_sort_by_price_top_test;

  localparam int PRICE_W       = rsbp_pkg::PRICE_W;
  localparam int TAG_W         = rsbp_pkg::TAG_W;
  localparam int CAPACITY      = 64;
  localparam int LOAD_TARGET   = 470;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [TAG_W-1:0]   TAG_MAX   = '1;

  // price draw styles for a run
  localparam int PRICE_WIDE    = 0;
  localparam int PRICE_CLUSTER = 1;
  localparam int PRICE_EDGES   = 2;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  rsbp_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  rsbp_pkg::out_item_t out_data_o;

  rsbp_pkg::in_item_t  load_queue[$];
  rsbp_pkg::out_item_t due_records[$];

  // mirror of the record store
  logic [PRICE_W-1:0] price_bank [CAPACITY];
  logic [TAG_W-1:0]   tag_bank [CAPACITY];
  int                 held_count  = 0;
  logic               lost_record = 1'b0;

  logic in_accepted = 1'b0;
  int   sent_count  = 0;
  int   taken_count = 0;
  int   cycle_count = 0;
  int   error_count = 0;

  wire in_steady  = (sent_count >= 200) && (sent_count < 320);
  wire out_steady = (taken_count >= 150) && (taken_count < 280);

  record_sort_by_price_top #(
    .MAX_ITEMS(CAPACITY),
    .TAG_BITS (TAG_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Store one record; on the final one, rank the set by price (stable)
  // and queue the whole run as expected results.
  task automatic store_and_rank(input rsbp_pkg::in_item_t rec);
    logic [PRICE_W-1:0]  key;
    logic [TAG_W-1:0]    tg;
    int                  j;
    rsbp_pkg::out_item_t res;
    if (held_count < CAPACITY) begin
      price_bank[held_count] = rec.price;
      tag_bank[held_count]   = rec.tag;
      held_count++;
    end else begin
      lost_record = 1'b1;
    end
    if (rec.final_item) begin
      // insertion sort: shift only past strictly greater prices
      for (int i = 1; i < held_count; i++) begin
        key = price_bank[i];
        tg  = tag_bank[i];
        j   = i;
        while (j > 0 && price_bank[j-1] > key) begin
          price_bank[j] = price_bank[j-1];
          tag_bank[j]   = tag_bank[j-1];
          j--;
        end
        price_bank[j] = key;
        tag_bank[j]   = tg;
      end
      for (int i = 0; i < held_count; i++) begin
        res.sorted_price = price_bank[i];
        res.sorted_tag   = tag_bank[i];
        res.end_of_run   = (i == held_count - 1);
        res.overflow     = lost_record;
        due_records.push_back(res);
      end
      held_count  = 0;
      lost_record = 1'b0;
    end
  endtask

  task automatic add_record(input logic [PRICE_W-1:0] price, input logic [TAG_W-1:0] tag,
                            input logic last);
    rsbp_pkg::in_item_t rec;
    rec.price      = price;
    rec.tag        = tag;
    rec.final_item = last;
    load_queue.push_back(rec);
  endtask

  function automatic logic [PRICE_W-1:0] draw_price(input int style);
    logic [31:0] raw;
    raw = $urandom();
    case (style)
      PRICE_CLUSTER: draw_price = PRICE_W'($urandom_range(0, 7));
      PRICE_EDGES: begin
        case ($urandom_range(0, 3))
          0:       draw_price = '0;
          1:       draw_price = PRICE_W'(1);
          2:       draw_price = PRICE_MAX - PRICE_W'(1);
          default: draw_price = PRICE_MAX;
        endcase
      end
      default: draw_price = raw[PRICE_W-1:0];
    endcase
  endfunction

  task automatic add_random_run(input int size);
    int style;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      style = PRICE_WIDE;
    end else if (pick < 8) begin
      style = PRICE_CLUSTER;
    end else begin
      style = PRICE_EDGES;
    end
    for (int i = 0; i < size; i++) begin
      add_record(draw_price(style), TAG_W'($urandom_range(0, 65535)), i == size - 1);
    end
  endtask

  // Driver: present the next record at the falling edge, hold while stalled.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_accepted)) begin
      if (load_queue.size() != 0 && (in_steady || $urandom_range(0, 99) >= 10)) begin
        in_data_i  <= load_queue.pop_front();
        in_valid_i <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !out_steady && ($urandom_range(0, 99) < 10);
  end

  // Monitor: record input transfers, check output transfers.
  always @(posedge clk_i) begin : watch
    rsbp_pkg::out_item_t want;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      in_accepted <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        store_and_rank(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        taken_count <= taken_count + 1;
        if (due_records.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data_o);
          error_count++;
        end else begin
          want = due_records.pop_front();
          if (out_data_o.sorted_price !== want.sorted_price) begin
            $display("%0t: sorted_price expected %0d actual %0d", $time,
                     want.sorted_price, out_data_o.sorted_price);
            error_count++;
          end
          if (out_data_o.sorted_tag !== want.sorted_tag) begin
            $display("%0t: sorted_tag expected %0d actual %0d", $time,
                     want.sorted_tag, out_data_o.sorted_tag);
            error_count++;
          end
          if (out_data_o.end_of_run !== want.end_of_run) begin
            $display("%0t: end_of_run expected %0b actual %0b", $time,
                     want.end_of_run, out_data_o.end_of_run);
            error_count++;
          end
          if (out_data_o.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     want.overflow, out_data_o.overflow);
            error_count++;
          end
        end
      end
    end
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, due_records.size());
      $display("[record_sort_by_price_top] ERROR");
      $finish;
    end
  end

  initial begin
    int loaded;
    int size;
    int pick;

    // single-record sets at both extremes
    add_record('0, '0, 1'b1);
    add_record(PRICE_MAX, TAG_MAX, 1'b1);
    // equal prices must keep load order
    add_record(5, 1, 1'b0);
    add_record(3, 2, 1'b0);
    add_record(5, 3, 1'b0);
    add_record(3, 4, 1'b0);
    add_record(PRICE_MAX, 5, 1'b0);
    add_record(0, 6, 1'b1);
    // descending, then already ascending
    add_record(40, 16'h00ff, 1'b0);
    add_record(30, 16'hff00, 1'b0);
    add_record(20, 16'h0f0f, 1'b0);
    add_record(10, 16'hf0f0, 1'b1);
    add_record(10, 16'h1234, 1'b0);
    add_record(20, 16'h5678, 1'b0);
    add_record(30, 16'h9abc, 1'b0);
    add_record(40, 16'hdef0, 1'b1);
    // ties at the price extremes
    add_record(PRICE_MAX, 16'haaaa, 1'b0);
    add_record(PRICE_MAX, 16'h5555, 1'b0);
    add_record(0, 16'hffff, 1'b0);
    add_record(0, 16'h0000, 1'b1);

    // exactly full, final dropped, and overflow with several dropped
    add_random_run(CAPACITY);
    add_random_run(CAPACITY + 1);
    add_random_run(CAPACITY + 6);
    loaded = load_queue.size();
    while (loaded < LOAD_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
      end else if (pick < 6) begin
        size = CAPACITY;
      end else if (pick < 20) begin
        size = $urandom_range(13, 40);
      end else begin
        size = $urandom_range(1, 12);
      end
      add_random_run(size);
      loaded += size;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (load_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[record_sort_by_price_top] OK");
    end else begin
      $display("[record_sort_by_price_top] ERROR");
    end
    $finish;
  end

endmodule
